// ----- hdl/dfs_pkg.sv -----
// Package with the request types, payload structs and constants of the diagonal fragment segmenter.
`default_nettype none

package dfs_pkg;

  localparam int POS_WIDTH_DEF   = 16;
  localparam int SCORE_WIDTH_DEF = 32;

  localparam int FIELD_POS_W = 16;
  localparam int DOT_SCORE_W = 16;
  localparam int FRAG_SCORE_W = 31;
  localparam int LEN_W       = 17;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [LEN_W-1:0]        LEN_MAX        = '1;
  localparam logic [FRAG_SCORE_W-1:0] FRAG_SCORE_MAX = '1;

  typedef enum logic {
    REQ_DOT   = 1'b0,
    REQ_FLUSH = 1'b1
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_GAP_OPEN   = 4'd0,
    REG_ROW_GAP_EXTEND = 4'd1,
    REG_COL_GAP_OPEN   = 4'd2,
    REG_COL_GAP_EXTEND = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    req_type_t                      req_type;
    logic [FIELD_POS_W-1:0]         dot_row;
    logic [FIELD_POS_W-1:0]         dot_col;
    logic signed [DOT_SCORE_W-1:0]  dot_score;
  } dot_req_t;

  typedef struct packed {
    logic [FIELD_POS_W-1:0]  first_row;
    logic [FIELD_POS_W-1:0]  first_col;
    logic [FIELD_POS_W-1:0]  end_row;
    logic [FIELD_POS_W-1:0]  end_col;
    logic [FRAG_SCORE_W-1:0] frag_score;
    logic [LEN_W-1:0]        frag_length;
    logic                    last_of_run;
  } frag_req_t;

endpackage

`default_nettype wire

// ----- hdl/diagonal_fragment_segmenter.sv -----
// Top level of the diagonal fragment segmenter: hit register, scoring logic and result register.
//
//   channel  direction  handshake               payload
//   dot      in         dot_valid / dot_stall   dot_req_t
//   frag     out        frag_valid / frag_stall frag_req_t
//   cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request per cycle is taken unless stalled; fragments pass the hit and result registers.
// The gap multiplies and the saturating add sit between the hit register and the state
// and result registers.
// Synchronous reset clears the run state, the gap registers and both valid flags.
// A held result stalls the hit register and, through it, the dot channel.
`default_nettype none

module diagonal_fragment_segmenter
  import dfs_pkg::*;
#(
  parameter int POS_WIDTH   = POS_WIDTH_DEF,
  parameter int SCORE_WIDTH = SCORE_WIDTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    dot_valid,
  output logic                   dot_stall,
  input  wire  dot_req_t         dot,
  output logic                   frag_valid,
  input  wire                    frag_stall,
  output frag_req_t              frag,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DIAG_W = POS_WIDTH + 1;
  localparam int GAP_W  = POS_WIDTH + 2;
  localparam int PROD_W = GAP_W + CFG_DATA_W;
  localparam int SUM_W  = ((SCORE_WIDTH > PROD_W) ? SCORE_WIDTH : PROD_W) + 3;
  localparam int EXT_W  = (SCORE_WIDTH > FRAG_SCORE_W) ? SCORE_WIDTH : FRAG_SCORE_W;

  localparam logic signed [SCORE_WIDTH-1:0] S_MAX = {1'b0, {(SCORE_WIDTH-1){1'b1}}};
  localparam logic signed [SCORE_WIDTH-1:0] S_MIN = {1'b1, {(SCORE_WIDTH-1){1'b0}}};
  localparam logic [EXT_W-1:0]              FRAG_MAX_EXT = EXT_W'(FRAG_SCORE_MAX);

  logic signed [CFG_DATA_W-1:0] row_gap_open, row_gap_extend, col_gap_open, col_gap_extend;

  logic                          diag_valid;
  logic signed [DIAG_W-1:0]      current_diag;
  logic                          prev_valid;
  logic [POS_WIDTH-1:0]          prev_row, prev_col;
  logic signed [SCORE_WIDTH-1:0] run_score;
  logic [LEN_W-1:0]              run_length;
  logic [POS_WIDTH-1:0]          start_row, start_col;

  logic     hit_valid;
  dot_req_t hit;

  logic blocked, fire;

  logic [POS_WIDTH-1:0]          r, c;
  logic signed [DOT_SCORE_W-1:0] sc;
  logic signed [DIAG_W-1:0]      diag;
  logic                          new_diag;
  logic signed [SCORE_WIDTH-1:0] eff_score;
  logic [LEN_W-1:0]              eff_len;
  logic                          eff_pv;
  logic signed [GAP_W-1:0]       d_row, d_col;
  logic signed [PROD_W-1:0]      row_prod, col_prod;
  logic signed [SUM_W-1:0]       row_cost, col_cost, ns_sum;
  logic signed [SCORE_WIDTH-1:0] ns_sat;
  logic                          ns_le0, sc_pos, qual, emit;
  logic [EXT_W-1:0]              score_ext;
  frag_req_t                     frag_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_gap_open   <= '0;
      row_gap_extend <= '0;
      col_gap_open   <= '0;
      col_gap_extend <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_GAP_OPEN:   row_gap_open   <= cfg_data;
        REG_ROW_GAP_EXTEND: row_gap_extend <= cfg_data;
        REG_COL_GAP_OPEN:   col_gap_open   <= cfg_data;
        REG_COL_GAP_EXTEND: col_gap_extend <= cfg_data;
        default: ;
      endcase
    end
  end

  assign blocked   = frag_valid && frag_stall;
  assign dot_stall = hit_valid && blocked;
  assign fire      = hit_valid && !blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (!dot_stall) begin
      hit_valid <= dot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dot_valid && !dot_stall) begin
      hit <= dot;
    end
  end

  always_comb begin
    r        = POS_WIDTH'(hit.dot_row);
    c        = POS_WIDTH'(hit.dot_col);
    sc       = hit.dot_score;
    diag     = $signed({1'b0, c}) - $signed({1'b0, r});
    new_diag = !diag_valid || (diag != current_diag);

    eff_score = new_diag ? '0 : run_score;
    eff_len   = new_diag ? '0 : run_length;
    eff_pv    = new_diag ? 1'b0 : prev_valid;

    d_row    = $signed({2'b00, r}) - $signed({2'b00, prev_row}) - GAP_W'(1);
    d_col    = $signed({2'b00, c}) - $signed({2'b00, prev_col}) - GAP_W'(1);
    row_prod = PROD_W'(d_row) * PROD_W'(row_gap_extend);
    col_prod = PROD_W'(d_col) * PROD_W'(col_gap_extend);
    row_cost = (!d_row[GAP_W-1] && d_row != '0) ?
               SUM_W'(row_gap_open) + SUM_W'(row_prod) : '0;
    col_cost = (!d_col[GAP_W-1] && d_col != '0) ?
               SUM_W'(col_gap_open) + SUM_W'(col_prod) : '0;

    ns_sum = SUM_W'(eff_score) + SUM_W'(sc);
    if (eff_pv) begin
      ns_sum = ns_sum + row_cost + col_cost;
    end
    if (ns_sum > SUM_W'(S_MAX)) begin
      ns_sat = S_MAX;
    end else if (ns_sum < SUM_W'(S_MIN)) begin
      ns_sat = S_MIN;
    end else begin
      ns_sat = SCORE_WIDTH'(ns_sum);
    end
    ns_le0 = ns_sat[SCORE_WIDTH-1] || (ns_sat == '0);
    sc_pos = !sc[DOT_SCORE_W-1] && (sc != '0);

    qual = !run_score[SCORE_WIDTH-1] && (run_score != '0) && (run_length > LEN_W'(1));
    emit = qual && ((hit.req_type == REQ_FLUSH) || new_diag || ns_le0);

    score_ext = EXT_W'(run_score);
    frag_next.first_row   = FIELD_POS_W'(start_row);
    frag_next.first_col   = FIELD_POS_W'(start_col);
    frag_next.end_row     = FIELD_POS_W'(prev_row);
    frag_next.end_col     = FIELD_POS_W'(prev_col);
    frag_next.frag_score  = (score_ext > FRAG_MAX_EXT) ? FRAG_SCORE_MAX :
                            FRAG_SCORE_W'(score_ext);
    frag_next.frag_length = run_length;
    frag_next.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diag_valid   <= 1'b0;
      current_diag <= '0;
      prev_valid   <= 1'b0;
      prev_row     <= '0;
      prev_col     <= '0;
      run_score    <= '0;
      run_length   <= '0;
      start_row    <= '0;
      start_col    <= '0;
    end else if (fire) begin
      if (hit.req_type == REQ_FLUSH) begin
        diag_valid   <= 1'b0;
        current_diag <= '0;
        prev_valid   <= 1'b0;
        prev_row     <= '0;
        prev_col     <= '0;
        run_score    <= '0;
        run_length   <= '0;
        start_row    <= '0;
        start_col    <= '0;
      end else begin
        diag_valid   <= 1'b1;
        current_diag <= diag;
        if (ns_le0) begin
          if (sc_pos) begin
            prev_valid <= 1'b1;
            prev_row   <= r;
            prev_col   <= c;
            start_row  <= r;
            start_col  <= c;
            run_score  <= SCORE_WIDTH'(sc);
            run_length <= LEN_W'(1);
          end else begin
            prev_valid <= 1'b0;
            run_score  <= '0;
            run_length <= '0;
          end
        end else begin
          if (eff_len == '0) begin
            start_row <= r;
            start_col <= c;
          end
          run_score  <= ns_sat;
          prev_valid <= 1'b1;
          prev_row   <= r;
          prev_col   <= c;
          run_length <= (eff_len != LEN_MAX) ? eff_len + LEN_W'(1) : eff_len;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frag_valid <= 1'b0;
    end else if (fire) begin
      frag_valid <= emit;
    end else if (!frag_stall) begin
      frag_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      frag <= frag_next;
    end
  end

`ifndef SYNTHESIS
  a_frag_qualifies: assert property (@(posedge clk) disable iff (rst)
    frag_valid |-> (frag.frag_length > LEN_W'(1)) && (frag.frag_score != '0)
                   && frag.last_of_run)
    else $error("fragment result does not qualify");

  a_len_needs_diag: assert property (@(posedge clk) disable iff (rst)
    (run_length != '0) |-> diag_valid)
    else $error("run length without a current diagonal");

  a_prev_needs_len: assert property (@(posedge clk) disable iff (rst)
    prev_valid |-> (run_length != '0))
    else $error("previous hit recorded with empty run");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && hit.req_type == REQ_FLUSH) |=> !diag_valid && (run_length == '0))
    else $error("flush did not clear the run state");
`endif

endmodule

`default_nettype wire

// ----- dv/diagonal_fragment_segmenter_tb.sv -----
// Testbench for the diagonal fragment segmenter: scoreboard, request drivers and result checks.
`timescale 1ns / 100ps

module diagonal_fragment_segmenter_tb
  import dfs_pkg::*;
();

  localparam longint SCORE_HI = 64'sd2147483647;
  localparam longint SCORE_LO = -SCORE_HI - 1;
  localparam int DRAIN_CYCLES = 10;
  localparam int LONG_RUN = 200;
  localparam int PHASE_ITEMS = 250;
  localparam int HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  class frag_scoreboard;
    logic signed [15:0] row_open, row_ext, col_open, col_ext;
    bit diag_open, prev_open;
    longint cur_diag, prev_row, prev_col, start_row, start_col, run_score;
    int unsigned run_length;
    frag_req_t expected_frags[$];
    int errors;

    function new();
      row_open = '0;
      row_ext = '0;
      col_open = '0;
      col_ext = '0;
      errors = 0;
      clear_run();
    endfunction

    function void clear_run();
      diag_open = 1'b0;
      prev_open = 1'b0;
      cur_diag = 0;
      prev_row = 0;
      prev_col = 0;
      start_row = 0;
      start_col = 0;
      run_score = 0;
      run_length = 0;
    endfunction

    function void set_gap(cfg_reg_t idx, logic [15:0] value);
      case (idx)
        REG_ROW_GAP_OPEN: row_open = value;
        REG_ROW_GAP_EXTEND: row_ext = value;
        REG_COL_GAP_OPEN: col_open = value;
        REG_COL_GAP_EXTEND: col_ext = value;
        default: ;
      endcase
    endfunction

    function void close_frag();
      frag_req_t f;
      if (run_score > 0 && run_length > 1) begin
        f.first_row = start_row[15:0];
        f.first_col = start_col[15:0];
        f.end_row = prev_row[15:0];
        f.end_col = prev_col[15:0];
        f.frag_score = (run_score > FRAG_SCORE_MAX) ? FRAG_SCORE_MAX
                                                    : run_score[FRAG_SCORE_W-1:0];
        f.frag_length = run_length[LEN_W-1:0];
        f.last_of_run = 1'b1;
        expected_frags = {expected_frags, f};
      end
    endfunction

    function void note_dot(dot_req_t d);
      longint r, c, sc, diag, ns, gap;
      if (d.req_type == REQ_FLUSH) begin
        close_frag();
        clear_run();
        return;
      end
      r = d.dot_row;
      c = d.dot_col;
      sc = $signed(d.dot_score);
      diag = c - r;
      if (!diag_open || diag != cur_diag) begin
        close_frag();
        diag_open = 1'b1;
        cur_diag = diag;
        prev_open = 1'b0;
        run_score = 0;
        run_length = 0;
      end
      ns = run_score + sc;
      if (prev_open) begin
        gap = r - prev_row - 1;
        if (gap > 0) ns += row_open + gap * row_ext;
        gap = c - prev_col - 1;
        if (gap > 0) ns += col_open + gap * col_ext;
      end
      if (ns > SCORE_HI) ns = SCORE_HI;
      else if (ns < SCORE_LO) ns = SCORE_LO;
      if (ns <= 0) begin
        close_frag();
        if (sc > 0) begin
          prev_open = 1'b1;
          prev_row = r;
          prev_col = c;
          start_row = r;
          start_col = c;
          run_score = sc;
          run_length = 1;
        end else begin
          prev_open = 1'b0;
          run_score = 0;
          run_length = 0;
        end
      end else begin
        if (run_length == 0) begin
          start_row = r;
          start_col = c;
        end
        run_score = ns;
        prev_open = 1'b1;
        prev_row = r;
        prev_col = c;
        if (run_length < LEN_MAX) run_length++;
      end
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_frag(frag_req_t got);
      frag_req_t want;
      if (expected_frags.size() == 0) begin
        $error("fragment %h arrived with no fragment expected", got);
        errors++;
        return;
      end
      want = expected_frags.pop_front();
      compare_field("first_row", want.first_row, got.first_row);
      compare_field("first_col", want.first_col, got.first_col);
      compare_field("end_row", want.end_row, got.end_row);
      compare_field("end_col", want.end_col, got.end_col);
      compare_field("frag_score", want.frag_score, got.frag_score);
      compare_field("frag_length", want.frag_length, got.frag_length);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

    function int pending();
      return expected_frags.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic dot_valid = 1'b0;
  logic dot_stall;
  dot_req_t dot = '0;
  logic frag_valid;
  logic frag_stall = 1'b0;
  frag_req_t frag;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frag_scoreboard sb;
  bit idle_on = 1'b1;
  int hold_req = 0;
  int hold_left = 0;
  int dots_sent = 0;
  int unsigned cycle_count = 0;

  diagonal_fragment_segmenter DUT (
    .clk(clk),
    .rst(rst),
    .dot_valid(dot_valid),
    .dot_stall(dot_stall),
    .dot(dot),
    .frag_valid(frag_valid),
    .frag_stall(frag_stall),
    .frag(frag),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("diagonal_fragment_segmenter_tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      frag_stall <= 1'b1;
    end else begin
      frag_stall <= idle_on && ($urandom_range(99) < 18);
    end
  end

  always @(posedge clk) begin
    if (!rst && frag_valid && !frag_stall) sb.check_frag(frag);
  end

  function automatic dot_req_t mk_dot(req_type_t kind, logic [15:0] row, logic [15:0] col,
                                      logic [15:0] score);
    dot_req_t d;
    d.req_type = kind;
    d.dot_row = row;
    d.dot_col = col;
    d.dot_score = score;
    return d;
  endfunction

  task automatic send_dot(dot_req_t d);
    while (idle_on && $urandom_range(99) < 18) begin
      dot_valid <= 1'b0;
      @(negedge clk);
    end
    dot <= d;
    dot_valid <= 1'b1;
    do @(posedge clk); while (dot_stall);
    sb.note_dot(d);
    dots_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    dot_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_gaps(logic [15:0] v0, logic [15:0] v1, logic [15:0] v2,
                            logic [15:0] v3);
    logic [15:0] vals[4];
    cfg_reg_t idx;
    vals = '{v0, v1, v2, v3};
    idx = idx.first();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_gap(idx, vals[i]);
      @(negedge clk);
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int count);
    int target, diag, r, n;
    logic [15:0] score;
    target = dots_sent + count;
    while (dots_sent < target) begin
      if ($urandom_range(99) < 80) begin
        diag = $urandom_range(400) - 200;
        r = $urandom_range(60000, 1000);
        n = $urandom_range(8, 1);
        repeat (n) begin
          if ($urandom_range(99) < 80) score = 16'($urandom_range(600, 32));
          else score = 16'(-$urandom_range(800, 1));
          send_dot(mk_dot(REQ_DOT, 16'(r), 16'(r + diag), score));
          r += 1 + (($urandom_range(3) == 0) ? $urandom_range(5, 1) : 0);
        end
      end else begin
        send_dot(mk_dot(req_type_t'($urandom_range(1)), 16'($urandom), 16'($urandom),
                        16'($urandom)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Zero gap costs: diagonal changes, zero and negative scores, extreme positions.
    send_dot(mk_dot(REQ_FLUSH, 16'd0, 16'd0, 16'd0));
    send_dot(mk_dot(REQ_DOT, 16'd10, 16'd10, 16'd256));
    send_dot(mk_dot(REQ_DOT, 16'd11, 16'd11, 16'd256));
    send_dot(mk_dot(REQ_DOT, 16'd5, 16'd6, 16'd256));
    send_dot(mk_dot(REQ_DOT, 16'd0, 16'hFFFF, 16'h7FFF));
    send_dot(mk_dot(REQ_DOT, 16'hFFFF, 16'd0, 16'h7FFF));
    send_dot(mk_dot(REQ_DOT, 16'hFFFF, 16'd0, 16'h8000));
    send_dot(mk_dot(REQ_DOT, 16'd100, 16'd100, 16'd512));
    send_dot(mk_dot(REQ_DOT, 16'd101, 16'd101, -16'sd256));
    send_dot(mk_dot(REQ_DOT, 16'd102, 16'd102, -16'sd512));
    send_dot(mk_dot(REQ_DOT, 16'd103, 16'd103, 16'd0));
    send_dot(mk_dot(REQ_DOT, 16'd104, 16'd104, 16'd300));
    send_dot(mk_dot(REQ_DOT, 16'd50, 16'd50, 16'd300));
    send_dot(mk_dot(REQ_FLUSH, 16'hA5C3, 16'h3C5A, 16'h8001));
    send_dot(mk_dot(REQ_DOT, 16'd0, 16'd0, 16'h7FFF));
    send_dot(mk_dot(REQ_DOT, 16'd1, 16'd1, 16'h7FFF));
    send_dot(mk_dot(REQ_FLUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    drain();

    // Largest gap costs drive the running score into both saturation limits; then moderate negative costs.
    write_gaps(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_dot(mk_dot(REQ_DOT, 16'd0, 16'd0, 16'd256));
    send_dot(mk_dot(REQ_DOT, 16'hFFFF, 16'hFFFF, 16'd256));
    send_dot(mk_dot(REQ_FLUSH, 16'd0, 16'd0, 16'd0));
    drain();
    write_gaps(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_dot(mk_dot(REQ_DOT, 16'd0, 16'd0, 16'h7FFF));
    send_dot(mk_dot(REQ_DOT, 16'hFFFF, 16'hFFFF, 16'h7FFF));
    send_dot(mk_dot(REQ_DOT, 16'hFFFF, 16'hFFFF, 16'd100));
    send_dot(mk_dot(REQ_FLUSH, 16'd0, 16'd0, 16'd0));
    drain();
    write_gaps(-16'sd256, -16'sd16, -16'sd128, -16'sd8);
    send_dot(mk_dot(REQ_DOT, 16'd200, 16'd300, 16'd256));
    send_dot(mk_dot(REQ_DOT, 16'd203, 16'd303, 16'd512));
    send_dot(mk_dot(REQ_FLUSH, 16'd0, 16'd0, 16'd0));
    drain();

    // A long fragment is sent with no idle cycles on either side.
    idle_on = 1'b0;
    repeat (LONG_RUN) send_dot(mk_dot(REQ_DOT, 16'd1000, 16'd1000, 16'd1));
    send_dot(mk_dot(REQ_FLUSH, 16'd0, 16'd0, 16'd0));
    drain();
    idle_on = 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_gaps(16'(-$urandom_range(512)), 16'(-$urandom_range(64)),
                      16'(-$urandom_range(512)), 16'(-$urandom_range(64)));
        1: write_gaps(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        2: write_gaps(16'(-$urandom_range(256)), 16'(-$urandom_range(32)),
                      16'(-$urandom_range(256)), 16'(-$urandom_range(32)));
        default: write_gaps(16'($urandom_range(256)), 16'($urandom_range(32)),
                            16'($urandom_range(256)), 16'($urandom_range(32)));
      endcase
      if (ph == 2) hold_req = HOLD_CYCLES;
      random_phase(PHASE_ITEMS);
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("diagonal_fragment_segmenter_tb: clean");
    end else begin
      $display("diagonal_fragment_segmenter_tb: errors");
    end
    $finish;
  end

endmodule

// ----- diagonal_fragment_segmenter.f -----
hdl/dfs_pkg.sv
hdl/diagonal_fragment_segmenter.sv
dv/diagonal_fragment_segmenter_tb.sv
